[src/pol_pkg.sv]
// Package for the positional ordered list: sizes, codes, word and command types.
package pol_pkg;

  localparam int unsigned CAPACITY = 256;
  localparam int unsigned CntW     = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW     = $clog2(CAPACITY);
  localparam int unsigned PosW     = 9;
  localparam int unsigned LenW     = 9;
  localparam int unsigned OpW      = 3;
  localparam int unsigned StW      = 2;
  localparam int unsigned DataW    = 32;
  localparam int unsigned CmpW     = ((CntW > PosW) ? CntW : PosW) + 1;

  localparam logic [OpW-1:0] OpInsFront = 3'd0;
  localparam logic [OpW-1:0] OpInsEnd   = 3'd1;
  localparam logic [OpW-1:0] OpInsAt    = 3'd2;
  localparam logic [OpW-1:0] OpDelFront = 3'd3;
  localparam logic [OpW-1:0] OpDelEnd   = 3'd4;
  localparam logic [OpW-1:0] OpDelAt    = 3'd5;

  localparam logic [StW-1:0] StDone  = 2'd0;
  localparam logic [StW-1:0] StFull  = 2'd1;
  localparam logic [StW-1:0] StEmpty = 2'd2;
  localparam logic [StW-1:0] StRange = 2'd3;

  typedef struct packed {
    logic [OpW-1:0]          operation;
    logic [PosW-1:0]         position;
    logic signed [DataW-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [StW-1:0]  status;
    logic [LenW-1:0] length;
  } out_word_t;

  typedef enum logic [1:0] {
    ShHold   = 2'd0,
    ShInsert = 2'd1,
    ShDelete = 2'd2
  } shift_e;

  // Broadcast to every cell of the row in the cycle a word is accepted.
  typedef struct packed {
    shift_e                  kind;
    logic [IdxW-1:0]         idx;
    logic signed [DataW-1:0] value;
  } cmd_t;

endpackage

[src/positional_ordered_list.sv]
// Top level of the positional ordered list: control, a row of cells and the result register.
//
// The block keeps an ordered list of up to CAPACITY signed 32-bit elements,
// addressed by 1-based positions. Each input word carries an operation
// (insert at front, at end or at a position; delete at front, at end or at a
// position), a position and a value. For every accepted word exactly one
// result word follows, giving a status and the length of the list afterwards.
// Both channels use a valid/ready handshake; a word moves when both are high.
// The elements live in a row of cells. On an insert every cell after the
// index takes the element of its left neighbour and the cell at the index loads
// the new value; on a delete every cell from the index onwards takes the element
// of its right neighbour. The whole row moves in the same clock edge.
// The result word is valid in the cycle after acceptance. The block takes one word
// per cycle while the result register is empty or drained, as the whole row shifts at once.
// When the receiver stalls, the result is held in the output register and the
// input stays ready only if that register is drained in the same cycle.
// Reset empties the list by clearing the count; cell contents are not cleared,
// as only cells below the count are ever part of the list.
module positional_ordered_list (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pol_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pol_pkg::out_word_t out_word_o
);
  import pol_pkg::*;

  logic                    in_fire;
  cmd_t                    cmd;
  out_word_t               res;
  logic [CntW-1:0]         count;
  logic signed [DataW-1:0] cell_data [CAPACITY];
  logic                    out_valid_q;
  out_word_t               out_word_q;

  // A new word is taken whenever the result register is empty or being drained.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  pol_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (in_fire),
    .word_i  (in_word_i),
    .cmd_o   (cmd),
    .res_o   (res),
    .count_o (count)
  );

  // The row of cells. The first cell's left input is never selected; the last cell's
  // right input is selected only on a delete, as that cell leaves the list, so both are tied to harmless values.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DataW-1:0] left, right;
    if (g == 0) begin : g_first
      assign left = cmd.value;
    end else begin : g_inner_l
      assign left = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner_r
      assign right = cell_data[g+1];
    end
    pol_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .cell_idx_i (IdxW'(g)),
      .left_i     (left),
      .right_i    (right),
      .data_o     (cell_data[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // The count never exceeds the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CntW'(CAPACITY))
    else $error("element count above capacity");

  // An insert at the front or end into a list that is not full succeeds and grows it by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (in_word_i.operation == OpInsFront || in_word_i.operation == OpInsEnd)
      && count != CntW'(CAPACITY))
    |=> (out_valid_o && out_word_o.status == StDone
      && out_word_o.length == LenW'($past(count) + CntW'(1))))
    else $error("insert at an end did not grow the list");

  // Any delete on an empty list is rejected and leaves it empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && count == '0 && (in_word_i.operation == OpDelFront
      || in_word_i.operation == OpDelEnd || in_word_i.operation == OpDelAt))
    |=> (out_valid_o && out_word_o.status == StEmpty && count == '0))
    else $error("delete on empty list not rejected");

endmodule

[src/pol_cell.sv]
// One storage cell of the list row: holds, loads, or takes its neighbour's element.
module pol_cell (
  input  logic                             clk_i,
  input  pol_pkg::cmd_t                    cmd_i,
  input  logic [pol_pkg::IdxW-1:0]         cell_idx_i,
  input  logic signed [pol_pkg::DataW-1:0] left_i,
  input  logic signed [pol_pkg::DataW-1:0] right_i,
  output logic signed [pol_pkg::DataW-1:0] data_o
);
  import pol_pkg::*;

  logic signed [DataW-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    unique case (cmd_i.kind)
      ShInsert: begin
        if (cell_idx_i == cmd_i.idx) begin
          data_d = cmd_i.value;
        end else if (cell_idx_i > cmd_i.idx) begin
          data_d = left_i;
        end
      end
      ShDelete: begin
        if (cell_idx_i >= cmd_i.idx) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

[src/pol_ctrl.sv]
// Control of the list: element count, range checks and the shift command for the row.
module pol_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  pol_pkg::in_word_t      word_i,
  output pol_pkg::cmd_t          cmd_o,
  output pol_pkg::out_word_t     res_o,
  output logic [pol_pkg::CntW-1:0] count_o
);
  import pol_pkg::*;

  logic [CntW-1:0] count_q, count_d;
  logic [CmpW-1:0] pos_w, cnt_w;
  logic [StW-1:0]  status;
  shift_e          kind;
  logic [IdxW-1:0] idx;

  assign pos_w = CmpW'(word_i.position);
  assign cnt_w = CmpW'(count_q);

  always_comb begin
    status = StDone;
    kind   = ShHold;
    idx    = '0;
    unique case (word_i.operation)
      OpInsFront, OpInsEnd, OpInsAt: begin
        if (count_q == CntW'(CAPACITY)) begin
          status = StFull;
        end else if (count_q == '0) begin
          kind = ShInsert;
        end else if (word_i.operation == OpInsFront) begin
          kind = ShInsert;
        end else if (word_i.operation == OpInsEnd) begin
          kind = ShInsert;
          idx  = IdxW'(count_q);
        end else if (pos_w == '0 || pos_w > cnt_w + CmpW'(1)) begin
          status = StRange;
        end else begin
          kind = ShInsert;
          idx  = IdxW'(pos_w - CmpW'(1));
        end
      end
      OpDelFront, OpDelEnd, OpDelAt: begin
        if (count_q == '0) begin
          status = StEmpty;
        end else if (word_i.operation == OpDelFront) begin
          kind = ShDelete;
        end else if (word_i.operation == OpDelEnd) begin
          kind = ShDelete;
          idx  = IdxW'(count_q - CntW'(1));
        end else if (pos_w == '0 || pos_w > cnt_w) begin
          status = StRange;
        end else begin
          kind = ShDelete;
          idx  = IdxW'(pos_w - CmpW'(1));
        end
      end
      default: status = StDone;
    endcase
  end

  always_comb begin
    unique case (kind)
      ShInsert: count_d = count_q + CntW'(1);
      ShDelete: count_d = count_q - CntW'(1);
      default:  count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (fire_i) begin
      count_q <= count_d;
    end
  end

  assign cmd_o.kind   = fire_i ? kind : ShHold;
  assign cmd_o.idx    = idx;
  assign cmd_o.value  = word_i.value;
  assign res_o.status = status;
  assign res_o.length = LenW'(count_d);
  assign count_o      = count_q;

endmodule
